// ===== hdl/life_pkg.sv =====
// ----------------------------------------------------------------------------
// life_pkg
// Shared types and constants of the life cellular automaton block: operation
// codes, controller states, register indexes and stream field widths.
// ----------------------------------------------------------------------------
package life_pkg;

  // default board size
  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // stream and register field widths
  localparam int MODE_W    = 3;
  localparam int IDX_W     = 6;
  localparam int LIVE_W    = 13;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;

  localparam logic [LIVE_W-1:0] COUNT_MAX = 13'd8191;
  localparam logic [CFG_W-1:0]  EXTENT_RESET = 7'd64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET     = 3'd0,
    MODE_TOGGLE  = 3'd1,
    MODE_STEP    = 3'd2,
    MODE_READ    = 3'd3,
    MODE_CLEAR   = 3'd4,
    MODE_FILL    = 3'd5,
    MODE_CHECKER = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SWEEP  = 2'd1,
    ST_FINISH = 2'd2
  } state_t;

endpackage

// ===== hdl/life_cellular_automaton_top.sv =====
// ----------------------------------------------------------------------------
// life_cellular_automaton_top
// Game of life (B3/S23) board held in a row memory, swept one row a cycle.
// ----------------------------------------------------------------------------
// Every transaction on the input stream runs one sweep over the active rows:
// each row is read from the board memory, pushed through a three-row window,
// rewritten by the requested operation and written back, while a two-level
// popcount accumulates the live count. The sweep runs at the pace of the
// single read port of the board memory (one row a cycle).
// A write to rows_in_use or cols_in_use starts a sweep over all MAX_ROWS rows
// that clears cells outside the new region and produces no result. The next
// item is taken while a finished result still waits on the output register.
// Cells outside the active region read as dead and the reported count
// saturates at 8191.
module life_cellular_automaton_top
  import life_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // mode [2:0], row [8:3], col [14:9], value [15]
  input  logic [IN_W-1:0]      in_tdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // cell_alive [0], live_count [13:1], zero [15:14]
  output logic [OUT_W-1:0]     out_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int RA_W  = $clog2(MAX_ROWS);
  localparam int RI_W  = $clog2(MAX_ROWS + 1);
  localparam int CI_W  = $clog2(MAX_COLS + 1);
  localparam int CNT_W = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int NG    = (MAX_COLS + 7) / 8;
  localparam int PC_W  = $clog2(MAX_COLS + 1);

  typedef logic [MAX_COLS-1:0] row_t;

  // board memory and per-row valid bits
  row_t             mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_r;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] rows_r, cols_r;
  logic [RI_W-1:0]  nr;
  logic [CI_W-1:0]  nc;
  row_t             colmask;

  // sweep control
  logic             iss_on_r, d_on_r, wr_on_r, g_on_r;
  logic [RI_W-1:0]  rd_idx_r, last_idx_r, d_idx_r;
  logic [RA_W-1:0]  rd_addr;
  row_t             q_r;
  logic             q_vld_r;
  row_t             prev_r, cur_r, in_row;
  row_t             new_row;
  row_t             wr_data_r;
  logic [RA_W-1:0]  wr_idx_r;
  logic [3:0]       grp_r [NG];
  logic [3:0]       grp_cnt [NG];
  logic [PC_W-1:0]  grp_sum;
  logic [CNT_W-1:0] acc_r;

  // item context
  mode_t            op_r;
  logic             is_item_r;
  logic             inside_r;
  logic             value_r;
  logic [RA_W-1:0]  tgt_row_r;
  row_t             tgt_mask_r;
  logic             cell_r;

  // output register
  logic             out_valid_r;
  logic             cell_out_r;
  logic [LIVE_W-1:0] cnt_out_r;

  // handshakes and decoded fields
  logic             item_go, cfg_write, cfg_go, sweep_go, pipe_empty, out_load;
  logic [IDX_W-1:0] in_row_f, in_col_f;
  logic             in_inside;
  row_t             in_mask;
  logic [RA_W-1:0]  cur_row;
  logic             row_hit;
  row_t             chk;
  logic [MAX_COLS+1:0] pp, cp, np;
  logic [3:0]       nbr;
  logic [NG*8-1:0]  wr_pad;

  assign in_row_f = in_tdata[8:3];
  assign in_col_f = in_tdata[14:9];

  // active extent saturates at the board size
  assign nr = (int'(rows_r) > MAX_ROWS) ? RI_W'(MAX_ROWS) : RI_W'(rows_r);
  assign nc = (int'(cols_r) > MAX_COLS) ? CI_W'(MAX_COLS) : CI_W'(cols_r);

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      colmask[j] = (j < int'(nc));
    end
  end

  assign in_inside = (int'(in_row_f) < int'(nr)) && (int'(in_col_f) < int'(nc));

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      in_mask[j] = in_inside && (int'(in_col_f) == j);
    end
  end

  assign item_go   = in_tvalid & in_tready;
  assign cfg_write = cfg_valid & cfg_ready;
  assign cfg_go    = cfg_write &&
                     ((cfg_index == REG_ROWS_IN_USE) || (cfg_index == REG_COLS_IN_USE));
  assign sweep_go  = item_go | cfg_go;
  assign pipe_empty = !iss_on_r && !d_on_r && !wr_on_r && !g_on_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sweep_go) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (pipe_empty) begin
          state_nxt = is_item_r ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    cfg_ready = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cfg_ready = 1'b1;
        in_tready = !cfg_valid;
      end
      ST_SWEEP: begin
      end
      ST_FINISH: begin
        out_load = !out_valid_r || out_tready;
      end
      default: begin
      end
    endcase
  end

  // read address; the extra index past the last row is never used
  assign rd_addr = (int'(rd_idx_r) >= MAX_ROWS) ? '0 : RA_W'(rd_idx_r);

  // incoming row, masked to the active region
  assign in_row = (d_on_r && q_vld_r && (d_idx_r < nr)) ? (q_r & colmask) : '0;

  assign cur_row = RA_W'(d_idx_r - 1'b1);
  assign row_hit = (cur_row == tgt_row_r);

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      chk[j] = colmask[j] & ((j % 2 == 1) ^ cur_row[0]);
    end
  end

  assign pp = {1'b0, prev_r, 1'b0};
  assign cp = {1'b0, cur_r, 1'b0};
  assign np = {1'b0, in_row, 1'b0};

  // new value of the row in the middle of the window
  always_comb begin
    new_row = cur_r;
    nbr     = '0;
    unique case (op_r)
      MODE_SET: begin
        if (row_hit) begin
          new_row = value_r ? (cur_r | tgt_mask_r) : (cur_r & ~tgt_mask_r);
        end
      end
      MODE_TOGGLE: begin
        if (row_hit) begin
          new_row = cur_r ^ tgt_mask_r;
        end
      end
      MODE_STEP: begin
        for (int j = 0; j < MAX_COLS; j++) begin
          nbr = 4'(pp[j]) + 4'(pp[j+1]) + 4'(pp[j+2]) + 4'(cp[j]) + 4'(cp[j+2])
              + 4'(np[j]) + 4'(np[j+1]) + 4'(np[j+2]);
          new_row[j] = colmask[j] & ((nbr == 4'd3) || (cur_r[j] && (nbr == 4'd2)));
        end
      end
      MODE_CLEAR:   new_row = '0;
      MODE_FILL:    new_row = colmask;
      MODE_CHECKER: new_row = cur_r | chk;
      default:      new_row = cur_r;
    endcase
  end

  // first popcount level: bytes
  assign wr_pad = (NG*8)'(wr_data_r);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_cnt[g] = '0;
      for (int b = 0; b < 8; b++) begin
        grp_cnt[g] = grp_cnt[g] + 4'(wr_pad[g*8+b]);
      end
    end
  end

  // second popcount level: sum of byte counts
  always_comb begin
    grp_sum = '0;
    for (int g = 0; g < NG; g++) begin
      grp_sum = grp_sum + PC_W'(grp_r[g]);
    end
  end

  // board memory
  always_ff @(posedge clk) begin
    if (iss_on_r) begin
      q_r <= mem[rd_addr];
    end
    if (wr_on_r) begin
      mem[wr_idx_r] <= wr_data_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rows_r      <= EXTENT_RESET;
      cols_r      <= EXTENT_RESET;
      row_vld_r   <= '0;
      iss_on_r    <= 1'b0;
      d_on_r      <= 1'b0;
      wr_on_r     <= 1'b0;
      g_on_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_write && (cfg_index == REG_ROWS_IN_USE)) begin
        rows_r <= cfg_data;
      end
      if (cfg_write && (cfg_index == REG_COLS_IN_USE)) begin
        cols_r <= cfg_data;
      end
      if (wr_on_r) begin
        row_vld_r[wr_idx_r] <= 1'b1;
      end
      if (sweep_go) begin
        iss_on_r <= 1'b1;
      end else if (iss_on_r && (rd_idx_r == last_idx_r)) begin
        iss_on_r <= 1'b0;
      end
      d_on_r  <= iss_on_r;
      wr_on_r <= d_on_r && (d_idx_r != '0);
      g_on_r  <= wr_on_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sweep datapath
  always_ff @(posedge clk) begin
    if (sweep_go) begin
      rd_idx_r   <= '0;
      last_idx_r <= item_go ? nr : RI_W'(MAX_ROWS);
      op_r       <= item_go ? mode_t'(in_tdata[2:0]) : MODE_READ;
      is_item_r  <= item_go;
      inside_r   <= item_go && in_inside;
      value_r    <= in_tdata[15];
      tgt_row_r  <= RA_W'(in_row_f);
      tgt_mask_r <= item_go ? in_mask : '0;
      prev_r     <= '0;
      cur_r      <= '0;
      acc_r      <= '0;
      cell_r     <= 1'b0;
    end else begin
      if (iss_on_r) begin
        rd_idx_r <= rd_idx_r + 1'b1;
        q_vld_r  <= row_vld_r[rd_addr];
        d_idx_r  <= rd_idx_r;
      end
      if (d_on_r) begin
        prev_r    <= cur_r;
        cur_r     <= in_row;
        wr_data_r <= new_row;
        wr_idx_r  <= cur_row;
      end
      if (wr_on_r) begin
        grp_r <= grp_cnt;
        if (wr_idx_r == tgt_row_r) begin
          cell_r <= |(wr_data_r & tgt_mask_r);
        end
      end
      if (g_on_r) begin
        acc_r <= acc_r + CNT_W'(grp_sum);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_out_r <= inside_r & cell_r;
      cnt_out_r  <= (int'(acc_r) > int'(COUNT_MAX)) ? COUNT_MAX : LIVE_W'(acc_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - LIVE_W - 1)'(0), cnt_out_r, cell_out_r};

endmodule

// ===== tb/life_cellular_automaton_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_cellular_automaton_top_tb
// Self-checking bench for the game of life board block. A shadow copy of the
// board tracks every accepted command and region resize and predicts the cell
// state and live count of each report. A directed opening covers corners,
// every operation and the region edge cases, then randomized phases resize the
// region and run seeded patterns through many generations. The command sender
// works in bursts and the report receiver stalls on changing patterns.
// ----------------------------------------------------------------------------
module life_cellular_automaton_top_tb;
  import life_pkg::*;

  localparam int ROWS = DEF_MAX_ROWS;
  localparam int COLS = DEF_MAX_COLS;
  localparam int RANDOM_ITEMS = 1550;
  localparam int SETTLE_CYCLES = 100;
  localparam int IDLE_LIMIT = 5000;

  // mode code with no operation behind it, and register indexes with no register
  localparam logic [MODE_W-1:0]    MODE_UNUSED  = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // cells whose column index is odd, and those whose index is even
  localparam logic [COLS-1:0] ODD_COLS  = {(COLS / 2){2'b10}};
  localparam logic [COLS-1:0] EVEN_COLS = {(COLS / 2){2'b01}};

  typedef struct packed {
    logic              value;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
    logic [MODE_W-1:0] mode;
  } command_t;

  typedef struct {
    bit              alive;
    bit [LIVE_W-1:0] count;
  } cell_report_t;

  class life_board_shadow;
    bit [COLS-1:0]   cells [ROWS];
    bit [CFG_W-1:0]  rows_reg = EXTENT_RESET;
    bit [CFG_W-1:0]  cols_reg = EXTENT_RESET;
    bit [LIVE_W-1:0] alive_total;
    cell_report_t    pending_reports[$];
    int              errors;

    function int row_extent();
      return (rows_reg > ROWS) ? ROWS : int'(rows_reg);
    endfunction

    function int col_extent();
      return (cols_reg > COLS) ? COLS : int'(cols_reg);
    endfunction

    function bit [COLS-1:0] col_mask();
      return {COLS{1'b1}} >> (COLS - col_extent());
    endfunction

    function void recount();
      int unsigned total = 0;
      for (int i = 0; i < row_extent(); i++) total += $countones(cells[i] & col_mask());
      alive_total = (total > COUNT_MAX) ? COUNT_MAX : total[LIVE_W-1:0];
    endfunction

    // one B3/S23 generation, cells outside the region count as dead
    function void advance();
      bit [COLS-1:0] prev [ROWS];
      int nr, nc, around, r, c;
      prev = cells;
      nr = row_extent();
      nc = col_extent();
      for (int i = 0; i < nr; i++) begin
        for (int j = 0; j < nc; j++) begin
          around = 0;
          for (int di = -1; di <= 1; di++) begin
            for (int dj = -1; dj <= 1; dj++) begin
              r = i + di;
              c = j + dj;
              if ((di != 0 || dj != 0) && r >= 0 && c >= 0 && r < nr && c < nc)
                around += prev[r][c];
            end
          end
          cells[i][j] = prev[i][j] ? (around == 2 || around == 3) : (around == 3);
        end
      end
    endfunction

    function void write_extent(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_ROWS_IN_USE) rows_reg = val;
      else if (idx == REG_COLS_IN_USE) cols_reg = val;
      else return;
      // resize wipes everything outside the new region
      for (int i = 0; i < ROWS; i++)
        cells[i] = (i < row_extent()) ? (cells[i] & col_mask()) : '0;
      recount();
    endfunction

    function void take_command(command_t cmd);
      int nr, nc;
      bit in_region;
      bit [COLS-1:0] mask;
      nr = row_extent();
      nc = col_extent();
      mask = col_mask();
      in_region = (cmd.row < nr) && (cmd.col < nc);
      case (cmd.mode)
        MODE_SET:    if (in_region) cells[cmd.row][cmd.col] = cmd.value;
        MODE_TOGGLE: if (in_region) cells[cmd.row][cmd.col] = ~cells[cmd.row][cmd.col];
        MODE_STEP:   advance();
        MODE_CLEAR:  for (int i = 0; i < nr; i++) cells[i] &= ~mask;
        MODE_FILL:   for (int i = 0; i < nr; i++) cells[i] |= mask;
        MODE_CHECKER: begin
          for (int i = 0; i < nr; i++) cells[i] |= mask & (i[0] ? EVEN_COLS : ODD_COLS);
        end
        default: ;
      endcase
      recount();
      pending_reports.push_back('{in_region ? cells[cmd.row][cmd.col] : 1'b0, alive_total});
    endfunction

    function void match_report(logic [OUT_W-1:0] data);
      cell_report_t want;
      if (pending_reports.size() == 0) begin
        $display("%0t: report %h arrived with none pending", $time, data);
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      if (data[0] !== want.alive) begin
        $display("%0t: cell_alive expected %0d got %0d", $time, want.alive, data[0]);
        errors++;
      end
      if (data[LIVE_W:1] !== want.count) begin
        $display("%0t: live_count expected %0d got %0d", $time, want.count, data[LIVE_W:1]);
        errors++;
      end
      if (data[OUT_W-1:LIVE_W+1] !== '0) begin
        $display("%0t: pad bits expected 0 got %b", $time, data[OUT_W-1:LIVE_W+1]);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  life_board_shadow shadow = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_style = 0;
  int style_left = 0;
  int stall_phase = 0;

  life_cellular_automaton_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver backpressure: the stall pattern is redrawn at random
  always @(posedge clk) begin
    if (style_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      style_left <= $urandom_range(50, 400);
    end else begin
      style_left <= style_left - 1;
    end
    stall_phase <= stall_phase + 1;
    case (stall_style)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= (stall_phase % 5) != 0;
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) shadow.match_report(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[life_cellular_automaton_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic command_t cmd_of(logic [MODE_W-1:0] mode, int row, int col, bit value);
    command_t cmd;
    cmd.mode = mode;
    cmd.row = row[IDX_W-1:0];
    cmd.col = col[IDX_W-1:0];
    cmd.value = value;
    return cmd;
  endfunction

  function automatic logic [CFG_W-1:0] pick_extent();
    case ($urandom_range(0, 19))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;
      4:       return 7'd2;
      default: return CFG_W'($urandom_range(1, 64));
    endcase
  endfunction

  // mostly in-region edits and generation steps, some whole-board ops and noise
  function automatic command_t random_command();
    command_t cmd;
    int pick, nr, nc;
    pick = $urandom_range(0, 99);
    nr = shadow.row_extent();
    nc = shadow.col_extent();
    cmd.value = ($urandom_range(0, 3) != 0);
    if (nr == 0 || nc == 0 || $urandom_range(0, 9) == 0) begin
      cmd.row = IDX_W'($urandom_range(0, ROWS - 1));
      cmd.col = IDX_W'($urandom_range(0, COLS - 1));
    end else begin
      cmd.row = IDX_W'($urandom_range(0, nr - 1));
      cmd.col = IDX_W'($urandom_range(0, nc - 1));
    end
    if (pick < 30)      cmd.mode = MODE_SET;
    else if (pick < 45) cmd.mode = MODE_TOGGLE;
    else if (pick < 67) cmd.mode = MODE_STEP;
    else if (pick < 85) cmd.mode = MODE_READ;
    else if (pick < 89) cmd.mode = MODE_CLEAR;
    else if (pick < 91) cmd.mode = MODE_FILL;
    else if (pick < 94) cmd.mode = MODE_CHECKER;
    else if (pick < 96) cmd.mode = MODE_UNUSED;
    else begin
      cmd.mode = MODE_SET;
      cmd.row = IDX_W'($urandom_range(0, ROWS - 1));
      cmd.col = IDX_W'($urandom_range(0, COLS - 1));
    end
    return cmd;
  endfunction

  task automatic send_command(command_t cmd);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(1, 90) : $urandom_range(1, 6))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_tdata <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    shadow.take_command(cmd);
    burst_left--;
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    while (shadow.pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    pause_until_drained();
    // let a resize sweep started earlier run out
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow.write_extent(idx, val);
  endtask

  initial begin
    int random_sent;
    int phase_len;
    command_t cmd;
    random_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, every operation, unused mode
    send_command(cmd_of(MODE_READ, 0, 0, 0));
    send_command(cmd_of(MODE_SET, 0, 0, 1));
    send_command(cmd_of(MODE_SET, 63, 63, 1));
    send_command(cmd_of(MODE_SET, 63, 0, 1));
    send_command(cmd_of(MODE_SET, 0, 63, 1));
    send_command(cmd_of(MODE_TOGGLE, 63, 63, 0));
    send_command(cmd_of(MODE_TOGGLE, 5, 7, 1));
    send_command(cmd_of(MODE_READ, 63, 0, 1));
    send_command(cmd_of(MODE_SET, 0, 0, 0));
    send_command(cmd_of(MODE_UNUSED, 0, 63, 1));
    send_command(cmd_of(MODE_CHECKER, 0, 1, 0));
    send_command(cmd_of(MODE_STEP, 10, 10, 0));
    send_command(cmd_of(MODE_FILL, 63, 63, 1));
    send_command(cmd_of(MODE_STEP, 0, 0, 0));
    send_command(cmd_of(MODE_CLEAR, 31, 31, 1));
    // glider
    send_command(cmd_of(MODE_SET, 1, 2, 1));
    send_command(cmd_of(MODE_SET, 2, 3, 1));
    send_command(cmd_of(MODE_SET, 3, 1, 1));
    send_command(cmd_of(MODE_SET, 3, 2, 1));
    send_command(cmd_of(MODE_SET, 3, 3, 1));
    send_command(cmd_of(MODE_STEP, 2, 2, 0));
    send_command(cmd_of(MODE_STEP, 3, 2, 0));

    // empty region, saturating extents, cells returning dead, unmapped indexes
    write_register(REG_ROWS_IN_USE, 7'd0);
    send_command(cmd_of(MODE_SET, 0, 0, 1));
    send_command(cmd_of(MODE_FILL, 0, 0, 0));
    write_register(REG_ROWS_IN_USE, 7'd127);
    write_register(REG_COLS_IN_USE, 7'd1);
    send_command(cmd_of(MODE_FILL, 5, 0, 0));
    send_command(cmd_of(MODE_READ, 5, 1, 0));
    write_register(REG_COLS_IN_USE, 7'd127);
    send_command(cmd_of(MODE_READ, 5, 0, 0));
    write_register(REG_ROWS_IN_USE, 7'd3);
    write_register(REG_COLS_IN_USE, 7'd3);
    send_command(cmd_of(MODE_STEP, 1, 1, 0));
    write_register(REG_SPARE_LO, 7'd5);
    write_register(REG_SPARE_HI, 7'd127);
    send_command(cmd_of(MODE_READ, 1, 1, 0));

    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) != 0) write_register(REG_ROWS_IN_USE, pick_extent());
      if ($urandom_range(0, 4) != 0) write_register(REG_COLS_IN_USE, pick_extent());
      // seeded pattern on a clean region, then let it evolve
      if ($urandom_range(0, 1) == 1) begin
        send_command(cmd_of(MODE_CLEAR, 0, 0, 0));
        repeat ($urandom_range(3, 24)) begin
          cmd = random_command();
          cmd.mode = MODE_SET;
          cmd.value = 1'b1;
          send_command(cmd);
          random_sent++;
        end
      end
      phase_len = $urandom_range(40, 120);
      for (int k = 0; k < phase_len; k++) begin
        send_command(random_command());
        random_sent++;
        if ($urandom_range(0, 59) == 0) pause_until_drained();
      end
    end

    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending_reports.size() == 0) begin
      $display("[life_cellular_automaton_top] OK");
    end else begin
      $display("[life_cellular_automaton_top] ERROR");
    end
    $finish;
  end

endmodule
